// ===== rtl/core/bbs_pkg.sv =====
`timescale 1ns / 1ps
// Block bubble sorter: shared constants, types and controller states.
// No dependencies; every other file uses it by scoped names.
package bbs_pkg;

  localparam int MAX_ITEMS    = 16;
  localparam int DATA_W       = 32;
  // count holds 0..MAX_ITEMS
  localparam int CNT_W        = $clog2(MAX_ITEMS + 1);
  // settle wait covers the longest insertion wavefront through the chain
  localparam int SETTLE_CYCLES = MAX_ITEMS;
  localparam int TMR_W        = $clog2(SETTLE_CYCLES + 1);

  // value traveling from one cell to its right neighbor
  typedef struct packed {
    logic                     vld;
    logic signed [DATA_W-1:0] val;
  } link_t;

  // held contents of one cell
  typedef struct packed {
    logic                     full;
    logic signed [DATA_W-1:0] val;
  } cell_state_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_DRAIN
  } ctrl_state_t;

endpackage

// ===== rtl/core/bbs_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sorter input and output beats.
// Depends on bbs_pkg for the data width.
interface bbs_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [bbs_pkg::DATA_W-1:0] value;
  logic                              last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface bbs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bbs_pkg::DATA_W-1:0] sorted_value;
  logic                              last_out;
  logic                              dropped;

  modport source (output valid, output sorted_value, output last_out, output dropped,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input dropped,
                  output ready);
endinterface

// ===== rtl/core/bbs_cell.sv =====
`timescale 1ns / 1ps
// One insertion cell: keeps the smaller of held and arriving value, passes the
// larger right; shifts left from its right neighbor while draining. Uses bbs_pkg.
module bbs_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 shift,
  input  bbs_pkg::link_t       link_in,
  output bbs_pkg::link_t       link_out,
  input  bbs_pkg::cell_state_t right,
  output bbs_pkg::cell_state_t held
);

  logic full;
  logic signed [bbs_pkg::DATA_W-1:0] val;
  logic out_vld;
  logic signed [bbs_pkg::DATA_W-1:0] out_val;

  // full flag and pass-on valid are control state
  always_ff @(posedge clk) begin
    if (rst) begin
      full    <= 1'b0;
      out_vld <= 1'b0;
    end else if (shift) begin
      full    <= right.full;
      out_vld <= 1'b0;
    end else if (link_in.vld) begin
      full    <= 1'b1;
      out_vld <= full;
    end else begin
      out_vld <= 1'b0;
    end
  end

  // payload: strict greater-than swap keeps equal values in arrival order
  always_ff @(posedge clk) begin
    if (shift) begin
      val <= right.val;
    end else if (link_in.vld) begin
      if (!full) begin
        val <= link_in.val;
      end else if (val > link_in.val) begin
        val     <= link_in.val;
        out_val <= val;
      end else begin
        out_val <= link_in.val;
      end
    end
  end

  assign link_out.vld = out_vld;
  assign link_out.val = out_val;
  assign held.full    = full;
  assign held.val     = val;

endmodule

// ===== rtl/core/bbs_ctrl.sv =====
`timescale 1ns / 1ps
// Sorter controller: load/settle/drain sequencing, element count, overflow flag
// and the injection register feeding the cell chain. Uses bbs_pkg and bbs_if.
module bbs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  bbs_in_if.sink               sort_in,
  bbs_out_if.source            sort_out,
  input  bbs_pkg::cell_state_t head,
  output logic                 shift,
  output bbs_pkg::link_t       inject
);

  bbs_pkg::ctrl_state_t state;
  bbs_pkg::ctrl_state_t state_next;
  logic [bbs_pkg::CNT_W-1:0] count;
  logic [bbs_pkg::TMR_W-1:0] timer;
  logic overflow;
  logic inj_vld;
  logic signed [bbs_pkg::DATA_W-1:0] inj_val;

  logic in_beat;
  logic out_beat;
  logic has_room;
  logic last_beat;

  assign in_beat   = sort_in.valid && sort_in.ready;
  assign out_beat  = sort_out.valid && sort_out.ready;
  assign has_room  = count < bbs_pkg::CNT_W'(bbs_pkg::MAX_ITEMS);
  assign last_beat = out_beat && (count == bbs_pkg::CNT_W'(1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bbs_pkg::ST_LOAD: begin
        if (in_beat && sort_in.last_item) state_next = bbs_pkg::ST_SETTLE;
      end
      bbs_pkg::ST_SETTLE: begin
        if (timer == '0) state_next = bbs_pkg::ST_DRAIN;
      end
      bbs_pkg::ST_DRAIN: begin
        if (last_beat) state_next = bbs_pkg::ST_LOAD;
      end
      default: state_next = bbs_pkg::ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    sort_in.ready = 1'b0;
    sort_out.valid = 1'b0;
    case (state)
      bbs_pkg::ST_LOAD:   sort_in.ready  = 1'b1;
      bbs_pkg::ST_SETTLE: sort_in.ready  = 1'b0;
      bbs_pkg::ST_DRAIN:  sort_out.valid = 1'b1;
      default: begin
        sort_in.ready  = 1'b0;
        sort_out.valid = 1'b0;
      end
    endcase
  end

  assign sort_out.sorted_value = head.val;
  assign sort_out.last_out     = (count == bbs_pkg::CNT_W'(1));
  assign sort_out.dropped      = (count == bbs_pkg::CNT_W'(1)) && overflow;
  assign shift                 = out_beat;
  assign inject.vld            = inj_vld;
  assign inject.val            = inj_val;

  // state, count, overflow, settle timer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bbs_pkg::ST_LOAD;
      count    <= '0;
      overflow <= 1'b0;
      timer    <= '0;
      inj_vld  <= 1'b0;
    end else begin
      state   <= state_next;
      inj_vld <= in_beat && has_room;
      if (in_beat) begin
        if (has_room) count <= count + bbs_pkg::CNT_W'(1);
        else overflow <= 1'b1;
        timer <= bbs_pkg::TMR_W'(bbs_pkg::SETTLE_CYCLES);
      end else if (state == bbs_pkg::ST_SETTLE && timer != '0) begin
        timer <= timer - bbs_pkg::TMR_W'(1);
      end
      if (out_beat) count <= count - bbs_pkg::CNT_W'(1);
      if (last_beat) overflow <= 1'b0;
    end
  end

  // injection payload
  always_ff @(posedge clk) begin
    if (in_beat) inj_val <= sort_in.value;
  end

  // count never exceeds the chain length
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= bbs_pkg::CNT_W'(bbs_pkg::MAX_ITEMS))
    else $error("element count beyond capacity");

  // a drop can only happen with the chain full
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (state == bbs_pkg::ST_LOAD && overflow) |-> count == bbs_pkg::CNT_W'(bbs_pkg::MAX_ITEMS))
    else $error("overflow flagged with free cells");

  // every drained beat comes from an occupied head cell
  a_head_full: assert property (@(posedge clk) disable iff (rst)
    sort_out.valid |-> (head.full && count != '0))
    else $error("draining an empty chain");

  // block end returns to an empty loading state
  a_block_end: assert property (@(posedge clk) disable iff (rst)
    last_beat |=> (state == bbs_pkg::ST_LOAD && count == '0 && !overflow))
    else $error("block did not clear after last beat");

endmodule

// ===== rtl/core/block_bubble_sorter.sv =====
`timescale 1ns / 1ps
// Top level of the block sorter: controller plus a chain of insertion cells.
// Depends on bbs_pkg, bbs_if, bbs_cell and bbs_ctrl.
//
//  channel   dir  beat fields                          handshake
//  sort_in   in   value[31:0] s, last_item             valid/ready
//  sort_out  out  sorted_value[31:0] s, last_out, dropped  valid/ready
//
// Loading takes one beat per cycle; each value ripples right through the cell
// chain, one cell per cycle, so the block is sorted while it loads.
// After the last beat the chain settles until the settle timer runs out, then drains
// one beat per cycle from the head cell while sort_out is ready.
// Input is not ready while settling or draining; an output stall freezes the chain.
// rst is synchronous: chain empty, count and overflow cleared, ready to load.
module block_bubble_sorter (
  input  logic       clk,
  input  logic       rst,
  bbs_in_if.sink     sort_in,
  bbs_out_if.source  sort_out
);

  bbs_pkg::link_t       link  [0:bbs_pkg::MAX_ITEMS];
  bbs_pkg::cell_state_t cells [0:bbs_pkg::MAX_ITEMS];
  logic                 shift;

  // beyond the last cell the chain reads as empty
  assign cells[bbs_pkg::MAX_ITEMS] = '0;

  bbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .sort_in  (sort_in),
    .sort_out (sort_out),
    .head     (cells[0]),
    .shift    (shift),
    .inject   (link[0])
  );

  // insertion chain
  for (genvar i = 0; i < bbs_pkg::MAX_ITEMS; i++) begin : g_cell
    bbs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (shift),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .right    (cells[i+1]),
      .held     (cells[i])
    );
  end

endmodule
